>>> rtl/rhsm_pkg.sv
package rhsm_pkg;

	// Default depth of the text window, which is also the longest usable pattern.
	localparam int MaxPatternDefault = 16;

	// Hash arithmetic: residues modulo 997 fit in ten bits.
	localparam int HashW = 10;
	// a * b + c with a, c below 997 and b at most 997 stays below 2^20.
	localparam int ProdW = 20;

	localparam logic [HashW-1:0] HashMod   = 10'd997;
	localparam logic [HashW-1:0] HashRadix = 10'd26;
	localparam logic [7:0]       DigitBase = 8'd97;
	// Value added to bytes below the digit base, so that the digit wraps modulo 997.
	localparam logic [HashW-1:0] DigitWrap = HashMod - {2'b00, DigitBase};
	// 1024 mod 997, used to fold the upper bits of a product back into range.
	localparam logic [4:0]       FoldConst = 5'd27;

	// Configuration register indexes.
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_PATTERN_LENGTH = 2'd0;
	localparam cfg_idx_t CFG_PATTERN_LOW    = 2'd1;
	localparam cfg_idx_t CFG_PATTERN_HIGH   = 2'd2;

	// Microprogram step addresses.
	localparam int StepW = 4;
	typedef logic [StepW-1:0] step_t;
	localparam step_t S_IDLE    = 4'd0;
	localparam step_t S_INIT    = 4'd1;
	localparam step_t S_PH_MUL  = 4'd2;
	localparam step_t S_PH_RED  = 4'd3;
	localparam step_t S_RM_MUL  = 4'd4;
	localparam step_t S_RM_RED  = 4'd5;
	localparam step_t S_BYTE    = 4'd6;
	localparam step_t S_RMV_MUL = 4'd7;
	localparam step_t S_RMV_RED = 4'd8;
	localparam step_t S_ADD_MUL = 4'd9;
	localparam step_t S_ADD_RED = 4'd10;
	localparam step_t S_CHK     = 4'd11;
	localparam step_t S_CMP     = 4'd12;
	localparam step_t S_EMIT    = 4'd13;

	typedef enum logic [1:0] {A_PH, A_RM, A_HASH} asel_t;
	typedef enum logic {B_RADIX, B_NEG_OLD} bsel_t;
	typedef enum logic [1:0] {CS_ZERO, CS_PAT_DIGIT, CS_HASH, CS_BYTE_DIGIT} csel_t;
	typedef enum logic [1:0] {D_NONE, D_PH, D_RM, D_HASH} dst_t;
	typedef enum logic [2:0] {
		CD_NEXT,
		CD_ALWAYS,
		CD_NOT_START,
		CD_NO_REMOVAL,
		CD_I_EQ_M,
		CD_HASH_MISS,
		CD_CMP_MORE
	} cond_t;

	// One control word of the microprogram.
	typedef struct packed {
		logic   wait_in;
		logic   init;
		logic   mul_en;
		asel_t  a_sel;
		bsel_t  b_sel;
		csel_t  c_sel;
		dst_t   dst;
		logic   i_clr;
		logic   i_inc;
		logic   shift;
		logic   ok_set;
		logic   cmp;
		logic   emit;
		cond_t  cond;
		step_t  target;
	} uword_t;

	// Digit of a text byte: (byte - 'a') mod 997.
	function automatic logic [HashW-1:0] digit_of(input logic [7:0] b);
		logic [HashW-1:0] d;
		if (b >= DigitBase) begin
			d = {2'b00, b - DigitBase};
		end else begin
			d = {2'b00, b} + DigitWrap;
		end
		return d;
	endfunction

	// Reduces a product below 2^20 modulo 997 by two folds and one subtraction.
	function automatic logic [HashW-1:0] hash_reduce(input logic [ProdW-1:0] x);
		logic [14:0] y;
		logic [10:0] z;
		y = 15'(x[19:10]) * 15'(FoldConst) + 15'(x[9:0]);
		z = 11'(y[14:10]) * 11'(FoldConst) + 11'(y[9:0]);
		if (z >= 11'(HashMod)) begin
			z = z - 11'(HashMod);
		end
		return z[HashW-1:0];
	endfunction

	// Microprogram ROM.
	function automatic uword_t ucode_word(input step_t pc);
		uword_t w;
		w = '0;
		unique case (pc)
			S_IDLE: begin
				w.wait_in = 1'b1;
				w.cond    = CD_NOT_START;
				w.target  = S_BYTE;
			end
			S_INIT: begin
				w.init = 1'b1;
				w.cond = CD_NEXT;
			end
			S_PH_MUL: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_PH;
				w.b_sel  = B_RADIX;
				w.c_sel  = CS_PAT_DIGIT;
				w.i_inc  = 1'b1;
			end
			S_PH_RED: begin
				w.dst    = D_PH;
				w.cond   = CD_I_EQ_M;
				w.target = S_BYTE;
			end
			S_RM_MUL: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_RM;
				w.b_sel  = B_RADIX;
				w.c_sel  = CS_ZERO;
			end
			S_RM_RED: begin
				w.dst    = D_RM;
				w.cond   = CD_ALWAYS;
				w.target = S_PH_MUL;
			end
			S_BYTE: begin
				w.i_clr  = 1'b1;
				w.cond   = CD_NO_REMOVAL;
				w.target = S_ADD_MUL;
			end
			S_RMV_MUL: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_RM;
				w.b_sel  = B_NEG_OLD;
				w.c_sel  = CS_HASH;
			end
			S_RMV_RED: begin
				w.dst = D_HASH;
			end
			S_ADD_MUL: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_HASH;
				w.b_sel  = B_RADIX;
				w.c_sel  = CS_BYTE_DIGIT;
			end
			S_ADD_RED: begin
				w.dst   = D_HASH;
				w.shift = 1'b1;
			end
			S_CHK: begin
				w.ok_set = 1'b1;
				w.cond   = CD_HASH_MISS;
				w.target = S_EMIT;
			end
			S_CMP: begin
				w.cmp    = 1'b1;
				w.i_inc  = 1'b1;
				w.cond   = CD_CMP_MORE;
				w.target = S_CMP;
			end
			S_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = CD_ALWAYS;
				w.target = S_IDLE;
			end
			default: begin
				w.cond   = CD_ALWAYS;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> rtl/rolling_hash_string_match.sv
// Each accepted text byte runs the byte steps: the new digit is added into the hash and the
// hash is checked; once the window is full the leaving byte is first taken out of the hash,
// and a hash hit adds a byte compare. A byte that starts a text first computes the pattern hash.
// One byte at a time: a new byte is taken only after the result step has loaded the result
// register, which waits while it is full and stalled; one shared multiply unit does all hashing.
// Reset (arst_n low, asynchronous): empty window, zero hashes and position, length one.
module rolling_hash_string_match import rhsm_pkg::*; #(
	parameter int MAX_PATTERN = MaxPatternDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// Text byte channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        start_of_text,
	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic        match_found,
	output logic [31:0] match_start,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_idx_t    cfg_index,
	input  logic [63:0] cfg_data
);

	// LenW holds a length up to MAX_PATTERN; IdxW indexes the window.
	localparam int LenW = $clog2(MAX_PATTERN + 1);
	localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// Configuration registers.
	logic [4:0]  pattern_length_q;
	logic [63:0] pat_low_q;
	logic [63:0] pat_high_q;

	// Sequencer and datapath registers.
	step_t            pc_q;
	logic [LenW-1:0]  m_q;
	logic [LenW-1:0]  i_q;
	logic [HashW-1:0] hash_q;
	logic [HashW-1:0] ph_q;
	logic [HashW-1:0] rm_q;
	logic [ProdW-1:0] prod_q;
	logic [31:0]      seen_q;
	logic [7:0]       byte_q;
	logic             ok_q;
	logic [7:0]       win_q [MAX_PATTERN];

	// Output register.
	logic        out_valid_q;
	logic        match_found_q;
	logic [31:0] match_start_q;

	uword_t           uw;
	logic             in_accept;
	logic             out_free;
	logic             hold;
	logic             cond_true;
	logic [LenW-1:0]  m_clamped;
	logic [LenW-1:0]  rd_diff;
	logic [7:0]       win_rd;
	logic [7:0]       pat_rd;
	logic [7:0]       pat_arr [MAX_PATTERN];
	logic             eligible;
	logic             no_removal;
	logic             byte_eq;
	logic [HashW-1:0] mul_a;
	logic [HashW-1:0] mul_b;
	logic [HashW-1:0] mul_c;
	logic [ProdW-1:0] mul_res;
	logic [HashW-1:0] red_res;

	// The configuration registers take a write in every cycle.
	assign cfg_ready = 1'b1;

	// The control word of the current step drives everything below.
	assign uw = ucode_word(pc_q);

	// A byte is taken only while the sequencer sits idle; the result register is separate,
	// so a new transaction can start while the previous result is still waiting.
	assign in_stall  = (pc_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// The sequencer holds in the idle step until a byte arrives and in the result step until
	// the output register is free.
	assign hold = (uw.wait_in && !in_accept) || (uw.emit && !out_free);

	// Pattern bytes laid out by position; positions beyond the two registers read as zero.
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pat
		if (j < 8) begin : g_low
			assign pat_arr[j] = pat_low_q[8*j +: 8];
		end else if (j < 16) begin : g_high
			assign pat_arr[j] = pat_high_q[8*(j-8) +: 8];
		end else begin : g_zero
			assign pat_arr[j] = 8'd0;
		end
	end

	// A length of zero counts as one and anything longer than the window as the window.
	always_comb begin
		if (pattern_length_q == 5'd0) begin
			m_clamped = LenW'(1);
		end else if (32'(pattern_length_q) > 32'(MAX_PATTERN)) begin
			m_clamped = LenW'(MAX_PATTERN);
		end else begin
			m_clamped = LenW'(pattern_length_q);
		end
	end

	// One window read port. With the counter cleared it addresses the byte that leaves the
	// window; during the compare it walks from the oldest byte towards the newest.
	assign rd_diff = m_q - LenW'(1) - i_q;
	assign win_rd  = win_q[rd_diff[IdxW-1:0]];
	assign pat_rd  = pat_arr[i_q[IdxW-1:0]];
	assign byte_eq = (win_rd == pat_rd);

	// seen_q is the position of the byte in hand until the result is sent.
	assign eligible   = (seen_q >= (32'(m_q) - 32'd1));
	assign no_removal = (seen_q < 32'(m_q));

	always_comb begin
		case (uw.cond)
			CD_NEXT:       cond_true = 1'b0;
			CD_ALWAYS:     cond_true = 1'b1;
			CD_NOT_START:  cond_true = !start_of_text;
			CD_NO_REMOVAL: cond_true = no_removal;
			CD_I_EQ_M:     cond_true = (i_q == m_q);
			CD_HASH_MISS:  cond_true = !(eligible && (hash_q == ph_q));
			CD_CMP_MORE:   cond_true = byte_eq && ((LenW+1)'(i_q) + (LenW+1)'(1) < (LenW+1)'(m_q));
			default:       cond_true = 1'b0;
		endcase
	end

	// The shared multiply-accumulate: a * b + c, reduced modulo 997 in the following step.
	// Taking the leaving digit out of the hash is done as a multiply by its complement.
	always_comb begin
		case (uw.a_sel)
			A_PH:    mul_a = ph_q;
			A_RM:    mul_a = rm_q;
			A_HASH:  mul_a = hash_q;
			default: mul_a = '0;
		endcase
		case (uw.b_sel)
			B_RADIX:   mul_b = HashRadix;
			B_NEG_OLD: mul_b = HashMod - digit_of(win_rd);
			default:   mul_b = HashRadix;
		endcase
		case (uw.c_sel)
			CS_ZERO:       mul_c = '0;
			CS_PAT_DIGIT:  mul_c = digit_of(pat_rd);
			CS_HASH:       mul_c = hash_q;
			CS_BYTE_DIGIT: mul_c = digit_of(byte_q);
			default:       mul_c = '0;
		endcase
	end

	assign mul_res = ProdW'(mul_a) * ProdW'(mul_b) + ProdW'(mul_c);
	assign red_res = hash_reduce(prod_q);

	// Configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= 5'd1;
			pat_low_q        <= '0;
			pat_high_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[4:0];
				CFG_PATTERN_LOW:    pat_low_q        <= cfg_data;
				CFG_PATTERN_HIGH:   pat_high_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else if (!hold) begin
			if (cond_true) begin
				pc_q <= uw.target;
			end else begin
				pc_q <= pc_q + step_t'(1);
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q    <= LenW'(1);
			i_q    <= '0;
			hash_q <= '0;
			ph_q   <= '0;
			rm_q   <= HashW'(1);
			prod_q <= '0;
			seen_q <= '0;
			byte_q <= '0;
			ok_q   <= 1'b0;
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			if (in_accept) begin
				byte_q <= text_byte;
			end
			if (uw.init) begin
				// A new text: latch the length, clear the window and start both hash chains.
				m_q    <= m_clamped;
				i_q    <= '0;
				hash_q <= '0;
				ph_q   <= '0;
				rm_q   <= HashW'(1);
				seen_q <= '0;
				for (int k = 0; k < MAX_PATTERN; k++) begin
					win_q[k] <= '0;
				end
			end
			if (uw.mul_en) begin
				prod_q <= mul_res;
			end
			case (uw.dst)
				D_PH:    ph_q   <= red_res;
				D_RM:    rm_q   <= red_res;
				D_HASH:  hash_q <= red_res;
				default: ;
			endcase
			if (uw.i_clr) begin
				i_q <= '0;
			end else if (uw.i_inc) begin
				i_q <= i_q + LenW'(1);
			end
			if (uw.shift) begin
				win_q[0] <= byte_q;
				for (int k = 1; k < MAX_PATTERN; k++) begin
					win_q[k] <= win_q[k-1];
				end
			end
			if (uw.ok_set) begin
				ok_q <= eligible && (hash_q == ph_q);
			end else if (uw.cmp && !byte_eq) begin
				ok_q <= 1'b0;
			end
			// The position advances once the result is loaded into the output register; it stops at the top.
			if (uw.emit && out_free && (seen_q != '1)) begin
				seen_q <= seen_q + 32'd1;
			end
		end
	end

	// Output register: loaded in the result step, released by the result transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			match_found_q <= 1'b0;
			match_start_q <= '0;
		end else begin
			if (uw.emit && out_free) begin
				out_valid_q   <= 1'b1;
				match_found_q <= ok_q;
				match_start_q <= ok_q ? (seen_q - 32'(m_q) + 32'd1) : 32'd0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign match_found = match_found_q;
	assign match_start = match_start_q;

	// A result only appears out of the result step.
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pc_q == S_EMIT))
		else $error("result raised outside the result step");

	// Every residue stays reduced, and the removal factor is never zero.
	a_residues: assert property (@(posedge clk) disable iff (!arst_n)
		(hash_q < HashMod) && (ph_q < HashMod) && (rm_q < HashMod) && (rm_q != '0))
		else $error("hash residue out of range");

	// The latched length lies between one and the window depth.
	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		(m_q != '0) && (m_q <= LenW'(MAX_PATTERN)))
		else $error("latched pattern length out of range");

	// The compare walk never runs past the pattern.
	a_cmp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_CMP) |-> (i_q < m_q))
		else $error("compare index beyond pattern length");

endmodule
